// ----- rtl/cws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform shaper package
// Port widths, waveform selector codes and fixed-point constants shared by
// the waveform shaper core and its sample datapath.
// ----------------------------------------------------------------------------
package cws_pkg;

    // Port widths
    localparam int WAVE_W   = 4;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;

    // Waveform selector codes; anything not listed here outputs silence
    typedef enum logic [WAVE_W-1:0] {
        WAVE_TRIANGLE = 4'd0,
        WAVE_TILT_SAW = 4'd1,
        WAVE_SAW      = 4'd2,
        WAVE_SQUARE   = 4'd3,
        WAVE_PULSE    = 4'd4,
        WAVE_ORGAN    = 4'd5,
        WAVE_NOISE    = 4'd6,
        WAVE_PHASER   = 4'd7
    } t_waveform;

    // Output levels in Q1.15
    localparam logic signed [SAMPLE_W-1:0] SQUARE_LEVEL = 16'sd16384; // 0.5
    localparam logic signed [SAMPLE_W-1:0] PULSE_LEVEL  = 16'sd22938; // 0.7

    // Phase fraction break points in Q0.16
    localparam logic [15:0] PULSE_EDGE = 16'd20480; // 5/16
    localparam logic [15:0] TILT_EDGE  = 16'd57344; // 7/8

    // Reciprocals for floor division by 5 and by 35 (exact over our ranges)
    localparam int          DIV5_SHIFT  = 21;
    localparam logic [20:0] DIV5_MUL    = 21'd419431;   // ceil(2^21 / 5)
    localparam int          DIV35_SHIFT = 27;
    localparam logic [21:0] DIV35_MUL   = 22'd3834793;  // ceil(2^27 / 35)

    // Offsets that keep the dividends positive, removed after the divide
    localparam logic [17:0] TRI_BIAS   = 18'd32768;
    localparam logic [17:0] TILT_BIAS  = 18'd29500;
    localparam logic [17:0] ORGAN_BIAS = 18'd28000;

endpackage

// ----- rtl/cws_shaper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform shaper datapath
// Combinational sample generator: turns a selector and a Q16.16 phase into a
// rounded Q1.15 sample using constant multiplies and shifts only.
// ----------------------------------------------------------------------------
module cws_shaper (
    input  logic        [cws_pkg::WAVE_W-1:0]   i_waveform,
    input  logic        [cws_pkg::PHASE_W-1:0]  i_phase,
    output logic signed [cws_pkg::SAMPLE_W-1:0] o_sample
);
    import cws_pkg::*;

    logic        [15:0] frac;
    logic signed [17:0] ramp2;      // 2f - 1.0
    logic        [16:0] tri_mag;    // |2f - 1.0|
    logic        [16:0] quad;       // (4t) mod 2
    logic signed [17:0] ramp4;
    logic        [16:0] quad_mag;
    logic        [20:0] num_tri;
    logic        [21:0] num_tilt_up;
    logic        [16:0] tilt_rest;
    logic        [22:0] num_tilt_dn;
    logic        [19:0] num_organ;
    logic        [18:0] div5_in;
    logic        [17:0] div5_bias;
    logic        [39:0] div5_prod;
    logic        [16:0] div5_q;
    logic        [17:0] div5_res;
    logic        [42:0] div35_prod;
    logic        [15:0] div35_q;
    logic        [22:0] detune;     // (phase * 127) mod 2^23
    logic        [22:0] detune_mag;
    logic        [24:0] phaser_sum;
    logic        [24:0] phaser_num;

    assign frac = i_phase[15:0];

    // Base triangle magnitude, shared by triangle, square, organ and phaser
    assign ramp2   = $signed({1'b0, frac, 1'b0}) - 18'sd65536;
    assign tri_mag = ramp2[17] ? 17'(-ramp2) : 17'(ramp2);

    // Double-rate triangle for the organ
    assign quad     = {i_phase[14:0], 2'b00};
    assign ramp4    = $signed({1'b0, quad}) - 18'sd65536;
    assign quad_mag = ramp4[17] ? 17'(-ramp4) : 17'(ramp4);

    // Biased dividends; each one rounds to nearest after its divide
    assign num_tri     = 21'(tri_mag) * 21'd14 + 21'd196618;
    assign num_tilt_up = 22'(frac) * 22'd72 + 22'd651;
    assign tilt_rest   = 17'd65536 - {1'b0, frac};
    assign num_tilt_dn = 23'(tilt_rest) * 23'd72 + 23'd93;
    assign num_organ   = 20'(quad_mag) * 20'd10 + 20'(tri_mag) * 20'd5 + 20'd2954;

    // Shared divide-by-5 (after a shift: divide by 4 for triangle and organ, by 2 for the tilted saw)
    always_comb begin
        case (i_waveform)
            WAVE_TILT_SAW: begin
                div5_in   = num_tilt_dn[19:1];
                div5_bias = TILT_BIAS;
            end
            WAVE_ORGAN: begin
                div5_in   = {1'b0, num_organ[19:2]};
                div5_bias = ORGAN_BIAS;
            end
            default: begin
                div5_in   = num_tri[20:2];
                div5_bias = TRI_BIAS;
            end
        endcase
    end

    assign div5_prod = 40'(div5_in) * 40'(DIV5_MUL);
    assign div5_q    = div5_prod[DIV5_SHIFT+16:DIV5_SHIFT];
    assign div5_res  = 18'(div5_q) - div5_bias;

    // Divide-by-70 for the rising part of the tilted saw (divide by 2 as a shift, then by 35)
    assign div35_prod = 43'(num_tilt_up[21:1]) * 43'(DIV35_MUL);
    assign div35_q    = div35_prod[DIV35_SHIFT+15:DIV35_SHIFT];

    // Detuned triangle for the phaser, Q22 units
    assign detune     = {frac, 7'b0} - i_phase[22:0];
    assign detune_mag = detune[22] ? {1'b0, detune[21:0]} : 23'd4194304 - detune;
    assign phaser_sum = {1'b0, tri_mag, 7'b0} + 25'(detune_mag);
    assign phaser_num = phaser_sum - 25'd8388480;

    // Output select
    always_comb begin
        case (i_waveform)
            WAVE_TRIANGLE: o_sample = $signed(div5_res[15:0]);
            WAVE_TILT_SAW: o_sample = (frac < TILT_EDGE) ?
                                      $signed(div35_q - 16'(TILT_BIAS)) :
                                      $signed(div5_res[15:0]);
            WAVE_SAW:      o_sample = $signed(frac);
            WAVE_SQUARE:   o_sample = (tri_mag >= 17'd32768) ? SQUARE_LEVEL : -SQUARE_LEVEL;
            WAVE_PULSE:    o_sample = (frac < PULSE_EDGE) ? PULSE_LEVEL : -PULSE_LEVEL;
            WAVE_ORGAN:    o_sample = $signed(div5_res[15:0]);
            WAVE_PHASER:   o_sample = $signed(phaser_num[23:8]);
            default:       o_sample = '0;   // noise and unused selectors
        endcase
    end

endmodule

// ----- rtl/chiptune_waveform_shaper_core.sv -----
`timescale 1ns / 1ps
// o_valid is registered: an accepted request sets r_in_valid, which in turn sets r_out_valid (o_valid).
// Throughput: one request per cycle; o_busy is always low.
// Stages: input register, constant-coefficient datapath, result register.
// Reset clears both valid flags; payload registers are not reset.
// Results appear for one cycle on o_valid and cannot be stalled.
// ----------------------------------------------------------------------------
// Chiptune waveform shaper core
// Registered oscillator sample generator for seven waveforms, Q1.15 output.
// ----------------------------------------------------------------------------
module chiptune_waveform_shaper_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic        [cws_pkg::WAVE_W-1:0]   i_waveform,
    input  logic        [cws_pkg::PHASE_W-1:0]  i_phase,
    output logic                                 o_valid,
    output logic signed [cws_pkg::SAMPLE_W-1:0] o_sample
);
    import cws_pkg::*;

    logic                       r_in_valid;
    logic [WAVE_W-1:0]          r_waveform;
    logic [PHASE_W-1:0]         r_phase;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic                       accept;

    // Pipeline never backs up
    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept;
            r_out_valid <= r_in_valid;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_waveform <= i_waveform;
            r_phase    <= i_phase;
        end
    end

    cws_shaper u_shaper (
        .i_waveform (r_waveform),
        .i_phase    (r_phase),
        .o_sample   (n_sample)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

`ifndef ASSERT_OFF
    // Every request yields a result through the input and result registers
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> ##1 o_valid)
        else $error("request did not produce a result");

    // No result without a staged request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_valid))
        else $error("result without a request");

    // Noise and unused selectors are silent
    a_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(r_waveform) == WAVE_NOISE || $past(r_waveform[3])))
        |-> (o_sample == '0))
        else $error("silent waveform produced a nonzero sample");

    // Square only takes its two levels
    a_square_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_waveform) == WAVE_SQUARE)
        |-> (o_sample == SQUARE_LEVEL || o_sample == -SQUARE_LEVEL))
        else $error("square sample off level");
`endif

endmodule

// ----- test/tb_chiptune_waveform_shaper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform shaper core testbench
// Drives selector/phase requests through the start/busy handshake and checks
// every strobed Q1.15 sample against an in-bench fixed-point waveform model,
// in request order. Directed edge cases first, then random requests under
// varying sender gaps.
// ----------------------------------------------------------------------------
module tb_chiptune_waveform_shaper_core;
    import cws_pkg::*;

    // Q16 phase fraction landmarks: waveform break points and zero crossings
    localparam logic [15:0] FRAC_QUARTER  = 16'h4000;
    localparam logic [15:0] FRAC_HALF     = 16'h8000;
    localparam logic [15:0] FRAC_3QUARTER = 16'hC000;
    localparam logic [15:0] FRAC_MAX      = 16'hFFFF;
    localparam longint      Q16_ONE       = 65536;
    localparam int          RANDOM_REQS   = 1100;

    // ------------------------------------------------------------------------
    // Sample scoreboard: predicts each request and checks strobed samples
    // ------------------------------------------------------------------------
    class sample_scoreboard;
        logic signed [SAMPLE_W-1:0] pending_samples[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // floor(n / d) for positive d
        function longint floor_quot(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        // round n/d to nearest, ties up, then clip to Q1.15
        function longint round_clip(longint n, longint d);
            longint v;
            v = floor_quot(n + d / 2, d);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v;
        endfunction

        function longint magnitude(longint x);
            return (x < 0) ? -x : x;
        endfunction

        // triangle 2*|2f-1|-1 in Q16
        function longint triangle_q16(logic [PHASE_W-1:0] phase);
            longint f;
            f = longint'(phase[15:0]);
            return 2 * magnitude(2 * f - Q16_ONE) - Q16_ONE;
        endfunction

        function logic signed [SAMPLE_W-1:0] shape_sample(logic [WAVE_W-1:0] wave,
                                                          logic [PHASE_W-1:0] phase);
            longint f, t1, t2, m1, m2, v;
            f = longint'(phase[15:0]);
            case (wave)
                WAVE_TRIANGLE: v = round_clip(triangle_q16(phase) * 7, 20);
                WAVE_TILT_SAW: begin
                    if (f < longint'(TILT_EDGE))
                        v = round_clip((16 * f - 7 * Q16_ONE) * 9, 140);
                    else
                        v = round_clip(((Q16_ONE - f) * 16 - Q16_ONE) * 9, 20);
                end
                WAVE_SAW:      v = (f < 32768) ? f : f - Q16_ONE;
                // zero triangle counts as positive
                WAVE_SQUARE:   v = (triangle_q16(phase) >= 0) ? longint'(SQUARE_LEVEL)
                                                              : -longint'(SQUARE_LEVEL);
                WAVE_PULSE:    v = (f < longint'(PULSE_EDGE)) ? longint'(PULSE_LEVEL)
                                                              : -longint'(PULSE_LEVEL);
                WAVE_ORGAN: begin
                    m1 = 4 * longint'(phase[14:0]);
                    m2 = 2 * f;
                    t1 = magnitude(m1 - Q16_ONE) - 32768;
                    t2 = magnitude(m2 - Q16_ONE) - 32768;
                    v = round_clip(10 * t1 + 5 * t2 - Q16_ONE, 20);
                end
                WAVE_PHASER: begin
                    m1 = 2 * f;
                    t1 = magnitude(m1 - Q16_ONE) - 32768;
                    // detuned copy uses the full phase, Q22 units
                    m2 = (longint'({32'd0, phase}) * 127) & 64'h7F_FFFF;
                    t2 = magnitude(m2 - 4194304) - 2097152;
                    v = round_clip(128 * t1 + t2 - 128 * 16384, 256);
                end
                // noise and out-of-range selectors are silent
                default:       v = 0;
            endcase
            return v[SAMPLE_W-1:0];
        endfunction

        function void note_request(logic [WAVE_W-1:0] wave, logic [PHASE_W-1:0] phase);
            pending_samples.push_back(shape_sample(wave, phase));
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] actual, realtime now);
            logic signed [SAMPLE_W-1:0] expected;
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected sample, expected none, actual %0d", now, actual);
            end else begin
                expected = pending_samples.pop_front();
                if (actual !== expected) begin
                    errors++;
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             now, expected, actual);
                end
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_start;
    logic                       o_busy;
    logic [WAVE_W-1:0]          i_waveform;
    logic [PHASE_W-1:0]         i_phase;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_sample;

    sample_scoreboard scoreboard = new();

    chiptune_waveform_shaper_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_waveform (i_waveform),
        .i_phase    (i_phase),
        .o_valid    (o_valid),
        .o_sample   (o_sample)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("chiptune_waveform_shaper_core regression: fail");
        $finish;
    end

    // Monitor: note accepted requests, check strobed samples
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                scoreboard.note_request(i_waveform, i_phase);
            if (o_valid)
                scoreboard.check_sample(o_sample, $realtime);
        end
    end

    // Hold one request until the block takes it
    task automatic send_request(logic [WAVE_W-1:0] wave, logic [PHASE_W-1:0] phase);
        @(negedge i_clk);
        i_start    <= 1'b1;
        i_waveform <= wave;
        i_phase    <= phase;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Random sender idle cycles, pct chance per cycle
    task automatic sender_gap(int pct);
        while ($urandom_range(0, 99) < pct) begin
            @(negedge i_clk);
            i_start    <= 1'b0;
            i_waveform <= 4'($urandom);
            i_phase    <= $urandom;
        end
    endtask

    // Random phase, often parked near a break point of some waveform
    function automatic logic [PHASE_W-1:0] pick_phase();
        logic [15:0] landmarks[7];
        logic [15:0] frac;
        landmarks = '{16'h0000, FRAC_QUARTER, PULSE_EDGE, FRAC_HALF,
                      FRAC_3QUARTER, TILT_EDGE, FRAC_MAX};
        if ($urandom_range(0, 3) == 0) begin
            frac = landmarks[$urandom_range(0, 6)] + 16'($urandom_range(0, 4)) - 16'd2;
            return {16'($urandom), frac};
        end
        return $urandom;
    endfunction

    // Stimulus
    initial begin
        logic [WAVE_W-1:0]  wave;
        logic [PHASE_W-1:0] phase;
        int                 gap_pct;
        int                 drain_cycles;

        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_waveform = '0;
        i_phase    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every selector, including noise and out-of-range codes
        for (int w = 0; w < 16; w++)
            send_request(4'(w), {16'(w * 4099), 16'(w * 4369)});
        // Field extremes and break points
        send_request(WAVE_PHASER, 32'hFFFF_FFFF);
        send_request(WAVE_PHASER, 32'h0000_0000);
        send_request(WAVE_SQUARE, {16'h1234, FRAC_QUARTER});
        send_request(WAVE_SQUARE, {16'h0000, FRAC_3QUARTER});
        send_request(WAVE_SAW, {16'hFFFF, FRAC_HALF});
        send_request(WAVE_PULSE, {16'h0000, PULSE_EDGE - 16'd1});
        send_request(WAVE_PULSE, {16'h0000, PULSE_EDGE});
        send_request(WAVE_TILT_SAW, {16'hFFFF, TILT_EDGE - 16'd1});
        send_request(WAVE_TILT_SAW, {16'h0000, TILT_EDGE});

        // Random requests: light gaps, heavy gaps, then back to back
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n < RANDOM_REQS / 3)
                gap_pct = 14;
            else if (n < 2 * RANDOM_REQS / 3)
                gap_pct = 56;
            else
                gap_pct = 0;
            sender_gap(gap_pct);
            if ($urandom_range(0, 99) < 85)
                wave = 4'($urandom_range(0, 7));
            else
                wave = 4'($urandom_range(8, 15));
            phase = pick_phase();
            send_request(wave, phase);
        end
        @(negedge i_clk);
        i_start <= 1'b0;

        // Drain outstanding samples, then a few quiet cycles
        drain_cycles = 0;
        while (scoreboard.pending_samples.size() != 0 && drain_cycles < 100) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (scoreboard.pending_samples.size() != 0) begin
            scoreboard.errors++;
            $display("%0t: %0d samples never arrived, expected %0d more, actual 0",
                     $realtime, scoreboard.pending_samples.size(),
                     scoreboard.pending_samples.size());
        end

        if (scoreboard.errors == 0)
            $display("chiptune_waveform_shaper_core regression: pass");
        else
            $display("chiptune_waveform_shaper_core regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cws_pkg.sv
rtl/cws_shaper.sv
rtl/chiptune_waveform_shaper_core.sv
test/tb_chiptune_waveform_shaper_core.sv
